// ===== rtl/nstk_pkg.sv =====
`timescale 1ns / 1ps
// Package for the nearest section top-k selector.
// Holds beat types, codes and fixed widths shared by the interfaces and modules.
package nstk_pkg;

    // Widest shift amount: fraction bits plus section size log2 stays below 32.
    localparam int SHIFT_W = 5;

    // Input opcodes.
    typedef enum logic [1:0] {
        OP_FRAME_START = 2'd0,
        OP_SECTION     = 2'd1,
        OP_FRAME_END   = 2'd2
    } t_op;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_TARGET  = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ENABLE          = 3'd0,
        CFG_SECTION_LOG2    = 3'd1,
        CFG_QUEUE_RADIUS_XZ = 3'd2,
        CFG_QUEUE_RADIUS_Y  = 3'd3,
        CFG_SYNC_RADIUS_XZ  = 3'd4,
        CFG_SYNC_RADIUS_Y   = 3'd5,
        CFG_SYNC_PER_FRAME  = 3'd6,
        CFG_FORCE_PER_FRAME = 3'd7
    } t_cfg_idx;

    // Main sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIST,
        S_SCAN,
        S_EMIT
    } t_state;

    // Distance unit phases.
    typedef enum logic [1:0] {
        D_IDLE,
        D_DIFF,
        D_MUL,
        D_ACC
    } t_dstate;

    // One input beat.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [15:0] section_x;
        logic signed [15:0] section_y;
        logic signed [15:0] section_z;
        logic               terrain_ready;
        logic               foliage_ready;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               last;
    } t_out_beat;

endpackage

// ===== rtl/nstk_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the selector: valid, ready and one input beat.
// Depends on nstk_pkg for the beat type.
interface nstk_in_if;
    logic               valid;
    logic               ready;
    nstk_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nstk_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the selector: valid, ready and one result beat.
// Depends on nstk_pkg for the beat type.
interface nstk_out_if;
    logic                valid;
    logic                ready;
    nstk_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nstk_dist.sv =====
`timescale 1ns / 1ps
// Squared distance unit: one shared 32x32 multiplier walked over the three axes.
// Depends on nstk_pkg for the phase type and shift width.
module nstk_dist #(
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [3:0]                   i_log2,
    input  logic signed [15:0]           i_sec_x,
    input  logic signed [15:0]           i_sec_y,
    input  logic signed [15:0]           i_sec_z,
    input  logic signed [31:0]           i_pos_x,
    input  logic signed [31:0]           i_pos_y,
    input  logic signed [31:0]           i_pos_z,
    output logic                         o_done,
    output logic [63:0]                  o_dist
);

    // Center is (2c+1) shifted by up to FRAC_BITS+15; camera is pos doubled.
    localparam int CW = 17 + FRAC_BITS + 15;
    localparam int DW = ((CW > 33) ? CW : 33) + 1;

    nstk_pkg::t_dstate r_state, n_state;
    logic [1:0]         r_axis;
    logic [31:0]        r_abs;
    logic               r_sat;
    logic [63:0]        r_sq;
    logic [63:0]        r_acc;
    logic               r_done;

    logic [nstk_pkg::SHIFT_W-1:0] shamt;
    logic signed [15:0]           coord;
    logic signed [31:0]           pos;
    logic signed [DW-1:0]         center;
    logic signed [DW-1:0]         cam2;
    logic signed [DW-1:0]         diff;
    logic [DW-1:0]                mag;
    logic [64:0]                  sum;

    assign shamt = nstk_pkg::SHIFT_W'(FRAC_BITS) + nstk_pkg::SHIFT_W'(i_log2);

    // Axis selection for the difference step.
    always_comb begin
        unique case (r_axis)
            2'd0: begin
                coord = i_sec_x;
                pos   = i_pos_x;
            end
            2'd1: begin
                coord = i_sec_y;
                pos   = i_pos_y;
            end
            default: begin
                coord = i_sec_z;
                pos   = i_pos_z;
            end
        endcase
    end

    // Offset from the camera to the section center, in half-LSB units.
    always_comb begin
        center = DW'($signed({coord, 1'b1})) <<< shamt;
        cam2   = DW'($signed({pos, 1'b0}));
        diff   = center - cam2;
        mag    = diff[DW-1] ? DW'(-diff) : DW'(diff);
        sum    = {1'b0, r_acc} + {1'b0, r_sq};
    end

    // Next phase.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nstk_pkg::D_IDLE: if (i_start) n_state = nstk_pkg::D_DIFF;
            nstk_pkg::D_DIFF: n_state = nstk_pkg::D_MUL;
            nstk_pkg::D_MUL:  n_state = nstk_pkg::D_ACC;
            nstk_pkg::D_ACC:  n_state = (r_axis == 2'd2) ? nstk_pkg::D_IDLE : nstk_pkg::D_DIFF;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nstk_pkg::D_IDLE;
            r_axis  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == nstk_pkg::D_ACC) && (r_axis == 2'd2);
            if (r_state == nstk_pkg::D_IDLE) begin
                r_axis <= 2'd0;
            end else if (r_state == nstk_pkg::D_ACC) begin
                r_axis <= r_axis + 2'd1;
            end
        end
    end

    // Datapath: magnitude, square, saturating accumulate.
    always_ff @(posedge i_clk) begin
        if (r_state == nstk_pkg::D_IDLE && i_start) begin
            r_acc <= '0;
        end
        if (r_state == nstk_pkg::D_DIFF) begin
            r_abs <= mag[31:0];
            r_sat <= |mag[DW-1:32];
        end
        if (r_state == nstk_pkg::D_MUL) begin
            r_sq <= r_sat ? '1 : (64'(r_abs) * 64'(r_abs));
        end
        if (r_state == nstk_pkg::D_ACC) begin
            r_acc <= sum[64] ? '1 : sum[63:0];
        end
    end

    assign o_done = r_done;
    assign o_dist = r_acc;

endmodule

// ===== rtl/nearest_section_top_k_selector_top.sv =====
`timescale 1ns / 1ps
// Nearest section top-k selector: requests per section, ranked targets per frame.
// Each item is accepted in idle, then decoded, and input is not ready until it ends; a
// ranked section then runs the distance unit (one multiplier over three axes, 9 steps
// plus done) and scans up to min(cand_count, capacity) entries, one entry per cycle.
// Frame end emits n targets then the done marker; a held result stalls decode and emit.
// Synchronous active-low reset restores register defaults and clears control and camera;
// list entries are read only below the fill count.
module nearest_section_top_k_selector_top #(
    parameter int MAX_TARGETS = 8,
    parameter int FRAC_BITS   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nstk_in_if.sink    i_in,
    nstk_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    // Capacity never exceeds 15 since the force count is four bits.
    localparam int DEPTH = (MAX_TARGETS < 15) ? MAX_TARGETS : 15;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [63:0]        dist_sq;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_cand;

    // Configuration registers.
    logic       r_enable;
    logic [3:0] r_log2;
    logic [7:0] r_qrxz, r_qry, r_srxz, r_sry, r_sync;
    logic [3:0] r_force;

    // Sequencer and state.
    nstk_pkg::t_state   r_state, n_state;
    nstk_pkg::t_in_beat r_item;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [15:0] r_sec_x, r_sec_y, r_sec_z;
    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    r_idx;
    logic [CNTW-1:0]    r_emit_n;
    t_cand              r_list [DEPTH];
    nstk_pkg::t_out_beat r_out;
    logic               r_out_valid;

    // Control decoded from the state.
    logic c_in_ready, c_cam_load, c_req_load, c_dist_start, c_end_load;
    logic c_scan_step, c_insert, c_tgt_load, c_done_load;

    logic                         out_free;
    logic [nstk_pkg::SHIFT_W-1:0] shamt;
    logic signed [31:0]           sh_x, sh_y, sh_z;
    logic signed [17:0]           dx, dy, dz;
    logic [16:0]                  ax, ay, az;
    logic                         in_queue, in_sync, want_req, want_rank;
    logic [7:0]                   cap8;
    logic [CNTW-1:0]              cap, fill, fill_next;
    logic                         dist_done;
    logic [63:0]                  sq_dist;
    t_cand                        cand_new, cand_rd;
    logic                         is_before;

    // Signed 32-bit section index clamped to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sd32767;
        end else if (v < -32'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Ranking order: distance, then x, y, z, all ascending.
    function automatic logic ranks_before(input t_cand a, input t_cand b);
        logic r;
        if (a.dist_sq != b.dist_sq) begin
            r = a.dist_sq < b.dist_sq;
        end else if (a.x != b.x) begin
            r = a.x < b.x;
        end else if (a.y != b.y) begin
            r = a.y < b.y;
        end else begin
            r = a.z < b.z;
        end
        return r;
    endfunction

    assign out_free = !r_out_valid || o_out.ready;

    // Camera section by flooring arithmetic shift.
    assign shamt = nstk_pkg::SHIFT_W'(FRAC_BITS) + nstk_pkg::SHIFT_W'(r_log2);
    assign sh_x  = r_item.cam_x >>> shamt;
    assign sh_y  = r_item.cam_y >>> shamt;
    assign sh_z  = r_item.cam_z >>> shamt;

    // Box tests against the stored camera section.
    always_comb begin
        dx = 18'(r_item.section_x) - 18'(r_sec_x);
        dy = 18'(r_item.section_y) - 18'(r_sec_y);
        dz = 18'(r_item.section_z) - 18'(r_sec_z);
        ax = dx[17] ? 17'(-dx) : 17'(dx);
        ay = dy[17] ? 17'(-dy) : 17'(dy);
        az = dz[17] ? 17'(-dz) : 17'(dz);
        in_queue = (ax <= 17'(r_qrxz)) && (ay <= 17'(r_qry)) && (az <= 17'(r_qrxz));
        in_sync  = (ax <= 17'(r_srxz)) && (ay <= 17'(r_sry)) && (az <= 17'(r_srxz));
        want_req = r_enable && in_queue && r_item.terrain_ready && !r_item.foliage_ready;
        want_rank = (r_sync != 8'd0) && in_sync;
    end

    // Capacity and fill level.
    always_comb begin
        cap8 = (8'(r_force) < r_sync) ? 8'(r_force) : r_sync;
        if (cap8 > 8'(DEPTH)) cap8 = 8'(DEPTH);
        cap       = cap8[CNTW-1:0];
        fill      = (r_count < cap) ? r_count : cap;
        fill_next = (fill < cap) ? fill + CNTW'(1) : fill;
    end

    // One list entry read per cycle, at the scan or emit index.
    always_comb begin
        cand_new.dist_sq = sq_dist;
        cand_new.x       = r_item.section_x;
        cand_new.y       = r_item.section_y;
        cand_new.z       = r_item.section_z;
        cand_rd          = r_list[r_idx[IDXW-1:0]];
        is_before        = ranks_before(cand_new, cand_rd);
    end

    nstk_dist #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_dist_start),
        .i_log2  (r_log2),
        .i_sec_x (r_item.section_x),
        .i_sec_y (r_item.section_y),
        .i_sec_z (r_item.section_z),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_pos_z (r_pos_z),
        .o_done  (dist_done),
        .o_dist  (sq_dist)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nstk_pkg::S_IDLE: begin
                if (i_in.valid) n_state = nstk_pkg::S_DECODE;
            end
            nstk_pkg::S_DECODE: begin
                priority case (r_item.opcode)
                    nstk_pkg::OP_SECTION: begin
                        if (!want_req) begin
                            n_state = nstk_pkg::S_IDLE;
                        end else if (out_free) begin
                            n_state = want_rank ? nstk_pkg::S_DIST : nstk_pkg::S_IDLE;
                        end
                    end
                    nstk_pkg::OP_FRAME_END: n_state = nstk_pkg::S_EMIT;
                    default:                n_state = nstk_pkg::S_IDLE;
                endcase
            end
            nstk_pkg::S_DIST: begin
                if (dist_done) n_state = nstk_pkg::S_SCAN;
            end
            nstk_pkg::S_SCAN: begin
                if (!(r_idx < fill && !is_before)) n_state = nstk_pkg::S_IDLE;
            end
            nstk_pkg::S_EMIT: begin
                if (out_free && !(r_idx < r_emit_n)) n_state = nstk_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        c_in_ready   = 1'b0;
        c_cam_load   = 1'b0;
        c_req_load   = 1'b0;
        c_dist_start = 1'b0;
        c_end_load   = 1'b0;
        c_scan_step  = 1'b0;
        c_insert     = 1'b0;
        c_tgt_load   = 1'b0;
        c_done_load  = 1'b0;
        unique case (r_state)
            nstk_pkg::S_IDLE: c_in_ready = 1'b1;
            nstk_pkg::S_DECODE: begin
                priority case (r_item.opcode)
                    nstk_pkg::OP_FRAME_START: c_cam_load = 1'b1;
                    nstk_pkg::OP_SECTION: begin
                        c_req_load   = want_req && out_free;
                        c_dist_start = want_req && out_free && want_rank;
                    end
                    nstk_pkg::OP_FRAME_END: c_end_load = 1'b1;
                    default: ;
                endcase
            end
            nstk_pkg::S_DIST: ;
            nstk_pkg::S_SCAN: begin
                c_scan_step = r_idx < fill && !is_before;
                c_insert    = !(r_idx < fill && !is_before) && (r_idx < cap);
            end
            nstk_pkg::S_EMIT: begin
                c_tgt_load  = out_free && (r_idx < r_emit_n);
                c_done_load = out_free && !(r_idx < r_emit_n);
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_log2   <= 4'd4;
            r_qrxz   <= 8'd2;
            r_qry    <= 8'd1;
            r_srxz   <= 8'd1;
            r_sry    <= 8'd1;
            r_sync   <= 8'd2;
            r_force  <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (nstk_pkg::t_cfg_idx'(i_cfg_idx))
                nstk_pkg::CFG_ENABLE:          r_enable <= i_cfg_data[0];
                nstk_pkg::CFG_SECTION_LOG2:    r_log2   <= i_cfg_data[3:0];
                nstk_pkg::CFG_QUEUE_RADIUS_XZ: r_qrxz   <= i_cfg_data;
                nstk_pkg::CFG_QUEUE_RADIUS_Y:  r_qry    <= i_cfg_data;
                nstk_pkg::CFG_SYNC_RADIUS_XZ:  r_srxz   <= i_cfg_data;
                nstk_pkg::CFG_SYNC_RADIUS_Y:   r_sry    <= i_cfg_data;
                nstk_pkg::CFG_SYNC_PER_FRAME:  r_sync   <= i_cfg_data;
                nstk_pkg::CFG_FORCE_PER_FRAME: r_force  <= i_cfg_data[3:0];
            endcase
        end
    end

    // Sequencer, camera, fill count, indexes and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nstk_pkg::S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_sec_x     <= '0;
            r_sec_y     <= '0;
            r_sec_z     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_emit_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_cam_load) begin
                r_pos_x <= r_item.cam_x;
                r_pos_y <= r_item.cam_y;
                r_pos_z <= r_item.cam_z;
                r_sec_x <= sat16(sh_x);
                r_sec_y <= sat16(sh_y);
                r_sec_z <= sat16(sh_z);
                r_count <= '0;
            end
            if (c_dist_start || c_end_load) begin
                r_idx <= '0;
            end else if (c_scan_step || c_tgt_load) begin
                r_idx <= r_idx + CNTW'(1);
            end
            if (c_end_load) begin
                r_emit_n <= r_enable ? fill : '0;
            end
            if (c_insert) begin
                r_count <= fill_next;
            end
            if (c_done_load) begin
                r_count <= '0;
            end
            if (c_req_load || c_tgt_load || c_done_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input beat capture.
    always_ff @(posedge i_clk) begin
        if (c_in_ready && i_in.valid) begin
            r_item <= i_in.data;
        end
    end

    // Sorted insertion: entries at and after the slot move down by one.
    always_ff @(posedge i_clk) begin
        if (c_insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CNTW'(i) == r_idx) begin
                    r_list[i] <= cand_new;
                end else if (i > 0 && CNTW'(i) > r_idx && CNTW'(i) < fill_next) begin
                    r_list[i] <= r_list[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (c_req_load) begin
            r_out.kind  <= nstk_pkg::KIND_REQUEST;
            r_out.out_x <= r_item.section_x;
            r_out.out_y <= r_item.section_y;
            r_out.out_z <= r_item.section_z;
            r_out.last  <= 1'b0;
        end else if (c_tgt_load) begin
            r_out.kind  <= nstk_pkg::KIND_TARGET;
            r_out.out_x <= cand_rd.x;
            r_out.out_y <= cand_rd.y;
            r_out.out_z <= cand_rd.z;
            r_out.last  <= 1'b0;
        end else if (c_done_load) begin
            r_out.kind  <= nstk_pkg::KIND_DONE;
            r_out.out_x <= '0;
            r_out.out_y <= '0;
            r_out.out_z <= '0;
            r_out.last  <= 1'b1;
        end
    end

    assign i_in.ready  = c_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
